[rtl/refcounted_page_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the page allocator
// Shorthand for clocked, reset-gated checks. The including module must
// provide clk and rst.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define RPA_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("page allocator check failed");

// Next-cycle implication
`define RPA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("page allocator check failed");

`endif

[rtl/rpa_pkg.sv]
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared constants for the reference-counted page allocator: parameter
// defaults, field widths, action and status codes, register indexes, register reset values.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int unsigned NUM_PAGES_DEF  = 1024;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned REF_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ACTION_W-1:0] ACT_INIT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADDREF = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_GETREF = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END  = 2'd2;

  localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] FIRST_FREE_RST  = 32'h8010_0000;
  localparam logic [ADDR_W-1:0] REGION_END_RST  = 32'h8040_0000;

endpackage

[rtl/refcounted_page_allocator.sv]
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page-frame allocator with a LIFO free stack and per-page reference counts.
// ----------------------------------------------------------------------------
// One item is taken at a time. For alloc, free, addref and getref the accept
// cycle issues the reads of the count memory and the free stack; the execute
// state then modifies and writes back and loads the result register once the
// output register is free. Init walks the whole table, one page per cycle,
// before its execute state. After reset a clearing pass over every page
// zeroes the count memory before the first item is taken; configuration
// writes are taken at all times. PAGE_BYTES must be a power of two. A result
// waiting in the output register does not stop the next item being accepted.
module refcounted_page_allocator #(
  parameter int unsigned NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = rpa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] phys_addr
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] page_addr, [47:32] ref_count,
                                      // [48] released, [50:49] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "refcounted_page_allocator_macros.svh"

  localparam int unsigned PB_LOG = $clog2(PAGE_BYTES);
  localparam int unsigned IDX_W  = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W  = $clog2(NUM_PAGES + 1);
  localparam logic [32:0] TABLE_BYTES = 33'(NUM_PAGES) << PB_LOG;
  localparam logic [32:0] PB_MASK33   = 33'(PAGE_BYTES - 1);
  localparam logic [33:0] PB_STEP     = 34'(PAGE_BYTES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t state;

  logic [31:0] region_base, first_free, region_end;
  logic [CNT_W-1:0] free_count, count_next;

  logic [IDX_W-1:0] walk_idx;
  logic [33:0]      walk_addr, walk_top;
  logic [32:0]      walk_lo;

  logic [2:0]       op_action;
  logic [IDX_W-1:0] op_idx;
  logic             op_in_table, op_free_ok;

  logic        out_valid;
  logic [31:0] out_page;
  logic [15:0] out_ref;
  logic        out_rel;
  logic [1:0]  out_status;

  // Accept-side decode
  logic             s_accept;
  logic [31:0]      acc_off;
  logic             acc_in_table, acc_free_ok;
  logic [IDX_W-1:0] acc_idx;
  logic [32:0]      acc_lo;

  // Memory ports
  logic                  ref_we, stk_we;
  logic [IDX_W-1:0]      ref_waddr, stk_waddr, stk_raddr;
  logic [COUNT_BITS-1:0] ref_wdata, ref_rdata;
  logic [IDX_W-1:0]      stk_wdata, stk_rdata;

  // Execute-side results
  logic                  slot_free, exec_fire, walk_hit;
  logic [31:0]           res_page;
  logic [COUNT_BITS-1:0] res_refc, ref_new;
  logic [31:0]           res_refc_wide;
  logic                  res_rel;
  logic [1:0]            res_status;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign acc_off      = s_axis_tdata - region_base;
  assign acc_in_table = {1'b0, acc_off} < TABLE_BYTES;
  assign acc_idx      = acc_off[PB_LOG +: IDX_W];
  assign acc_free_ok  = (({1'b0, acc_off} & PB_MASK33) == '0) &&
                        (s_axis_tdata >= first_free) && (s_axis_tdata < region_end) &&
                        acc_in_table;
  assign acc_lo       = ({1'b0, first_free} + PB_MASK33) & ~PB_MASK33;
  assign stk_raddr    = IDX_W'(free_count - CNT_W'(1));

  assign slot_free = !out_valid || m_axis_tready;
  assign exec_fire = (state == ST_EXEC) && slot_free;
  assign walk_hit  = (walk_addr >= {1'b0, walk_lo}) && (walk_top <= {2'b0, region_end});

  rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (s_accept),
    .raddr (acc_idx),
    .rdata (ref_rdata)
  );

  rpa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (s_accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign ref_new = (ref_rdata == COUNT_MAX) ? ref_rdata : ref_rdata + COUNT_ONE;

  // Writes of the two memories (clearing pass, init walk, read-modify-write of an item), and the result of the item
  always_comb begin
    ref_we     = 1'b0;
    ref_waddr  = walk_idx;
    ref_wdata  = '0;
    stk_we     = 1'b0;
    stk_waddr  = IDX_W'(free_count);
    stk_wdata  = walk_idx;
    count_next = free_count;
    res_page   = '0;
    res_refc   = '0;
    res_rel    = 1'b0;
    res_status = rpa_pkg::ST_OK;
    case (state)
      ST_CLEAR: begin
        ref_we = 1'b1;
      end
      ST_WALK: begin
        if (walk_hit) begin
          ref_we = 1'b1;
          if (free_count < CNT_FULL) begin
            stk_we     = 1'b1;
            count_next = free_count + CNT_W'(1);
          end
        end
      end
      ST_EXEC: begin
        ref_waddr = op_idx;
        stk_wdata = op_idx;
        case (op_action)
          rpa_pkg::ACT_ALLOC: begin
            if (free_count == '0) begin
              res_status = rpa_pkg::ST_NO_PAGES;
            end else begin
              count_next = free_count - CNT_W'(1);
              ref_we     = exec_fire;
              ref_waddr  = stk_rdata;
              ref_wdata  = COUNT_ONE;
              res_page   = region_base + (32'(stk_rdata) << PB_LOG);
              res_refc   = COUNT_ONE;
            end
          end
          rpa_pkg::ACT_FREE: begin
            if (!op_free_ok) begin
              res_status = rpa_pkg::ST_BAD_ADDR;
            end else if (ref_rdata > COUNT_ONE) begin
              ref_we    = exec_fire;
              ref_wdata = ref_rdata - COUNT_ONE;
              res_refc  = ref_rdata - COUNT_ONE;
            end else begin
              ref_we = exec_fire;
              if (free_count < CNT_FULL) begin
                stk_we     = exec_fire;
                count_next = free_count + CNT_W'(1);
                res_rel    = 1'b1;
              end else begin
                res_status = rpa_pkg::ST_OVERFLOW;
              end
            end
          end
          rpa_pkg::ACT_ADDREF: begin
            if (op_in_table) begin
              ref_we    = exec_fire;
              ref_wdata = ref_new;
              res_refc  = ref_new;
            end
          end
          rpa_pkg::ACT_GETREF: begin
            res_refc = op_in_table ? ref_rdata : COUNT_ONE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign res_refc_wide = 32'(res_refc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      walk_idx    <= '0;
      free_count  <= '0;
      out_valid   <= 1'b0;
      region_base <= rpa_pkg::REGION_BASE_RST;
      first_free  <= rpa_pkg::FIRST_FREE_RST;
      region_end  <= rpa_pkg::REGION_END_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rpa_pkg::REG_REGION_BASE: region_base <= cfg_data;
          rpa_pkg::REG_FIRST_FREE:  first_free  <= cfg_data;
          rpa_pkg::REG_REGION_END:  region_end  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          if (walk_idx == LAST_IDX) begin
            walk_idx <= '0;
            state    <= ST_IDLE;
          end else begin
            walk_idx <= walk_idx + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser == rpa_pkg::ACT_INIT) begin
              free_count <= '0;
              walk_idx   <= '0;
              state      <= ST_WALK;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_WALK: begin
          free_count <= count_next;
          walk_idx   <= walk_idx + IDX_W'(1);
          if (walk_idx == LAST_IDX) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            free_count <= count_next;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: operands, walk position, result
  always_ff @(posedge clk) begin
    if (s_accept) begin
      op_action   <= s_axis_tuser;
      op_idx      <= acc_idx;
      op_in_table <= acc_in_table;
      op_free_ok  <= acc_free_ok;
      walk_addr   <= {2'b0, region_base};
      walk_top    <= {2'b0, region_base} + PB_STEP;
      walk_lo     <= acc_lo;
    end else if (state == ST_WALK) begin
      walk_addr <= walk_addr + PB_STEP;
      walk_top  <= walk_top + PB_STEP;
    end
    if (exec_fire) begin
      out_page   <= res_page;
      out_ref    <= res_refc_wide[15:0];
      out_rel    <= res_rel;
      out_status <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_status, out_rel, out_ref, out_page};

  `RPA_ASSERT_IMP(a_no_result_overwrite, exec_fire, !out_valid || m_axis_tready)
  `RPA_ASSERT_NEXT(a_accept_starts_work, s_accept, state == ST_EXEC || state == ST_WALK)
  `RPA_ASSERT_IMP(a_count_bound, 1'b1, free_count <= CNT_FULL)
  `RPA_ASSERT_IMP(a_count_step, !$past(rst) && $past(state) != ST_WALK && $past(state) != ST_IDLE, free_count == $past(free_count) || free_count == $past(free_count) + CNT_W'(1) || free_count == $past(free_count) - CNT_W'(1))

endmodule

[rtl/rpa_ram.sv]
// ----------------------------------------------------------------------------
// rpa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module rpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
